/* src/partition_refinability_checker_defines.svh */
// ----------------------------------------------------------------------------
// Partition refinability checker assertion macros
// Shared property wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PARTITION_REFINABILITY_CHECKER_DEFINES_SVH
`define PARTITION_REFINABILITY_CHECKER_DEFINES_SVH
`ifndef SYNTH
`define PRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PRC_ASSERT_SAME(label, clk, rst, ante, cons)
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg
// Types, codes and constants of the partition refinability checker.
// ----------------------------------------------------------------------------
package prc_pkg;
   localparam int VALUE_BITS      = 16;
   localparam int SUM_W           = VALUE_BITS + 1;
   localparam int MAX_CLASSES_DEF = 256;
   localparam logic [SUM_W-1:0] INF_SUM = SUM_W'(1) << VALUE_BITS;

   localparam logic [1:0] VERDICT_NONE    = 2'd0;
   localparam logic [1:0] VERDICT_REFINE  = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;
   localparam logic [1:0] VERDICT_CAP     = 2'd3;

   localparam logic [1:0] PHASE_PREFIX = 2'd0;
   localparam logic [1:0] PHASE_TABLE  = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [1:0]            verdict;
      logic [VALUE_BITS-1:0] refine_point;
   } rsp_type;
endpackage

/* src/prc_class_mem.sv */
// ----------------------------------------------------------------------------
// prc_class_mem
// Class minimum store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prc_class_mem #(
   parameter int MAX_CLASSES = prc_pkg::MAX_CLASSES_DEF,
   localparam int IDX_W = $clog2(MAX_CLASSES)
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [IDX_W-1:0]          waddr,
   input  logic [prc_pkg::SUM_W-1:0] wdata,
   input  logic [IDX_W-1:0]          raddr,
   output logic [prc_pkg::SUM_W-1:0] rdata
);
   logic [prc_pkg::SUM_W-1:0] mem [MAX_CLASSES];
   logic [prc_pkg::SUM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* src/prc_ctrl.sv */
// ----------------------------------------------------------------------------
// prc_ctrl
// Item sequencer: prefix scan, table clear and hole insertion over the store.
// ----------------------------------------------------------------------------
`include "partition_refinability_checker_defines.svh"

module prc_ctrl #(
   parameter int MAX_CLASSES = prc_pkg::MAX_CLASSES_DEF,
   localparam int IDX_W = $clog2(MAX_CLASSES),
   localparam int CNT_W = $clog2(MAX_CLASSES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  prc_pkg::req_type          req_item,
   output logic                      rsp_strobe,
   output prc_pkg::rsp_type          rsp_item,
   output logic                      mem_we,
   output logic [IDX_W-1:0]          mem_waddr,
   output logic [prc_pkg::SUM_W-1:0] mem_wdata,
   output logic [IDX_W-1:0]          mem_raddr,
   input  logic [prc_pkg::SUM_W-1:0] mem_rdata
);
   localparam int VB = prc_pkg::VALUE_BITS;
   localparam int SW = prc_pkg::SUM_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EVAL   = 4'd1;
   localparam logic [3:0] ST_CLEAR  = 4'd2;
   localparam logic [3:0] ST_TLOOP  = 4'd3;
   localparam logic [3:0] ST_FINAL  = 4'd4;
   localparam logic [3:0] ST_HR0    = 4'd5;
   localparam logic [3:0] ST_HRJ    = 4'd6;
   localparam logic [3:0] ST_LA     = 4'd7;
   localparam logic [3:0] ST_LI     = 4'd8;
   localparam logic [3:0] ST_LJ     = 4'd9;
   localparam logic [3:0] ST_HDONE  = 4'd10;
   localparam logic [3:0] ST_FINISH = 4'd11;

   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b,
                                                input logic [CNT_W-1:0] m);
      logic [IDX_W:0] s;
      logic [IDX_W:0] mm;
      s  = {1'b0, a} + {1'b0, b};
      mm = (IDX_W+1)'(m);
      if (s >= mm) begin
         s = s - mm;
      end
      return s[IDX_W-1:0];
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [VB-1:0]    v_ff, v_in;
   logic             last_ff, last_in;
   logic [VB-1:0]    prev_ff, prev_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       hv_ff, hv_in;
   logic [VB-1:0]    hp_ff, hp_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]    ne_ff, ne_in;
   logic [IDX_W-1:0] ner_ff, ner_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             strobe_ff, strobe_in;
   prc_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW:0]      sum_wide;
   logic             i_more;
   logic [IDX_W-1:0] ner_next;

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      last_in   = last_ff;
      prev_in   = prev_ff;
      phase_in  = phase_ff;
      hv_in     = hv_ff;
      hp_in     = hp_ff;
      m_in      = m_ff;
      cnt_in    = cnt_ff;
      ne_in     = ne_ff;
      ner_in    = ner_ff;
      i_in      = i_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      mem_waddr = ner_ff;
      mem_wdata = ne_ff;
      mem_raddr = ner_ff;
      sum_wide  = {1'b0, mem_rdata} + {1'b0, ne_ff};
      i_more    = (CNT_W'(i_ff) + CNT_W'(1)) < m_ff;
      ner_next  = add_mod(ner_ff, IDX_W'(1), m_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               v_in     = req_item.value;
               last_in  = req_item.last;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
            prev_in  = v_ff;
            if (hv_ff != prc_pkg::VERDICT_INVALID) begin
               if (v_ff <= prev_ff) begin
                  hv_in    = prc_pkg::VERDICT_INVALID;
                  hp_in    = '0;
                  phase_in = prc_pkg::PHASE_DONE;
               end else if (phase_ff == prc_pkg::PHASE_PREFIX) begin
                  if ({1'b0, v_ff} == ne_ff) begin
                     ne_in = ne_ff + SW'(1);
                  end else if (ne_ff > SW'(MAX_CLASSES)) begin
                     hv_in    = prc_pkg::VERDICT_CAP;
                     hp_in    = '0;
                     phase_in = prc_pkg::PHASE_DONE;
                  end else begin
                     m_in     = CNT_W'(ne_ff);
                     cnt_in   = '0;
                     ne_in    = ne_ff + SW'(1);
                     ner_in   = (ne_ff == SW'(1)) ? IDX_W'(0) : IDX_W'(1);
                     i_in     = '0;
                     phase_in = prc_pkg::PHASE_TABLE;
                     state_in = ST_CLEAR;
                  end
               end else if (phase_ff == prc_pkg::PHASE_TABLE) begin
                  state_in = ST_TLOOP;
               end
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = prc_pkg::INF_SUM;
            if (i_more) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               state_in = ST_TLOOP;
            end
         end
         ST_TLOOP: begin
            mem_raddr = ner_ff;
            state_in  = (ne_ff < {1'b0, v_ff}) ? ST_HR0 : ST_FINAL;
         end
         ST_FINAL: begin
            state_in = ST_FINISH;
            if (mem_rdata <= {1'b0, v_ff}) begin
               hv_in    = prc_pkg::VERDICT_REFINE;
               hp_in    = v_ff;
               phase_in = prc_pkg::PHASE_DONE;
            end else begin
               ne_in  = {1'b0, v_ff} + SW'(1);
               ner_in = ner_next;
            end
         end
         ST_HR0: begin
            if (mem_rdata < ne_ff) begin
               if (sum_wide < (SW+1)'(prc_pkg::INF_SUM)) begin
                  mem_raddr = add_mod(ner_ff, ner_ff, m_ff);
                  idx_in    = mem_raddr;
                  sum_in    = sum_wide[SW-1:0];
                  state_in  = ST_HRJ;
               end else begin
                  ne_in    = ne_ff + SW'(1);
                  ner_in   = ner_next;
                  state_in = ST_TLOOP;
               end
            end else if (m_ff == CNT_W'(1)) begin
               state_in = ST_HDONE;
            end else begin
               i_in     = IDX_W'(1);
               state_in = ST_LA;
            end
         end
         ST_HRJ: begin
            if (sum_ff < mem_rdata) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = sum_ff;
            end
            ne_in    = ne_ff + SW'(1);
            ner_in   = ner_next;
            state_in = ST_TLOOP;
         end
         ST_LA: begin
            mem_raddr = i_ff;
            state_in  = ST_LI;
         end
         ST_LI: begin
            if (sum_wide < (SW+1)'(prc_pkg::INF_SUM)) begin
               mem_raddr = add_mod(i_ff, ner_ff, m_ff);
               idx_in    = mem_raddr;
               sum_in    = sum_wide[SW-1:0];
               state_in  = ST_LJ;
            end else if (i_more) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_LA;
            end else begin
               state_in = ST_HDONE;
            end
         end
         ST_LJ: begin
            if (sum_ff < mem_rdata) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = sum_ff;
            end
            if (i_more) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_LA;
            end else begin
               state_in = ST_HDONE;
            end
         end
         ST_HDONE: begin
            mem_we    = 1'b1;
            mem_waddr = ner_ff;
            mem_wdata = ne_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            if ((cnt_ff + CNT_W'(1)) >= m_ff) begin
               hv_in    = prc_pkg::VERDICT_REFINE;
               hp_in    = v_ff;
               phase_in = prc_pkg::PHASE_DONE;
               state_in = ST_FINISH;
            end else begin
               ne_in    = ne_ff + SW'(1);
               ner_in   = ner_next;
               state_in = ST_TLOOP;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
            if (last_ff) begin
               strobe_in           = 1'b1;
               rsp_in.verdict      = hv_ff;
               rsp_in.refine_point = (hv_ff == prc_pkg::VERDICT_REFINE) ? hp_ff : '0;
               prev_in             = '0;
               phase_in            = prc_pkg::PHASE_PREFIX;
               hv_in               = prc_pkg::VERDICT_NONE;
               hp_in               = '0;
               m_in                = '0;
               cnt_in              = '0;
               ne_in               = SW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prev_ff   <= '0;
         phase_ff  <= prc_pkg::PHASE_PREFIX;
         hv_ff     <= prc_pkg::VERDICT_NONE;
         hp_ff     <= '0;
         m_ff      <= '0;
         cnt_ff    <= '0;
         ne_ff     <= SW'(1);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prev_ff   <= prev_in;
         phase_ff  <= phase_in;
         hv_ff     <= hv_in;
         hp_ff     <= hp_in;
         m_ff      <= m_in;
         cnt_ff    <= cnt_in;
         ne_ff     <= ne_in;
         strobe_ff <= strobe_in;
      end
      v_ff    <= v_in;
      last_ff <= last_in;
      ner_ff  <= ner_in;
      i_ff    <= i_in;
      sum_ff  <= sum_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `PRC_ASSERT_NEXT(a_rsp_after_last, clock, reset, state_ff == ST_FINISH && last_ff, rsp_strobe)
   `PRC_ASSERT_SAME(a_rsp_needs_last, clock, reset, rsp_strobe, $past(last_ff))
   `PRC_ASSERT_SAME(a_point_nonzero, clock, reset,
      rsp_strobe && rsp_item.verdict == prc_pkg::VERDICT_REFINE, rsp_item.refine_point != '0)
   `PRC_ASSERT_SAME(a_waddr_in_class, clock, reset, mem_we, CNT_W'(mem_waddr) < m_ff)
   `PRC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, cnt_ff <= m_ff)
endmodule

/* src/partition_refinability_checker.sv */
// ----------------------------------------------------------------------------
// partition_refinability_checker
// Checks a strictly increasing sequence for refinability over residue classes.
// ----------------------------------------------------------------------------
// channel   ports                         handshake
// request   req_item (value, last)        start & !busy
// response  rsp_item (verdict, point)     rsp_strobe, one cycle, no stall
//
// Prefix, invalid and decided items pass EVAL then FINISH back to IDLE.
// Finding the modulus m adds CLEAR over all m classes; a table item passes
// EVAL, TLOOP, FINAL and FINISH, and each missing value below it adds TLOOP, HR0
// and HRJ, or, if the value excludes its class, LA, LI, LJ per other class
// (read, read, write) and HDONE. Reset is synchronous; the store is cleared
// when the modulus is found. The result strobe rises in the cycle after FINISH.
// ----------------------------------------------------------------------------
module partition_refinability_checker #(
   parameter int MAX_CLASSES = prc_pkg::MAX_CLASSES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prc_pkg::req_type req_item,
   output logic             rsp_strobe,
   output prc_pkg::rsp_type rsp_item
);
   localparam int IDX_W = $clog2(MAX_CLASSES);

   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [IDX_W-1:0]          mem_raddr;
   logic [prc_pkg::SUM_W-1:0] mem_wdata;
   logic [prc_pkg::SUM_W-1:0] mem_rdata;

   prc_ctrl #(.MAX_CLASSES(MAX_CLASSES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   prc_class_mem #(.MAX_CLASSES(MAX_CLASSES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );
endmodule
